/* sv/aabbbp_pkg.sv */
// ============================================================================
// aabbbp_pkg
// Shared types, constants and box widening helpers for the AABB broad phase.
// ============================================================================
package aabbbp_pkg;

    localparam int COORD_W   = 20;
    localparam int VERT_W    = 16;
    localparam int MARGIN_W  = 18;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = MARGIN_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 1'd1;

    // request operation codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic [VERT_W-1:0] va;
        logic [VERT_W-1:0] vb;
        logic [VERT_W-1:0] vc;
        t_point            lo;
        t_point            hi;
    } t_entry;

    // low side minus margin, clamped at the most negative coordinate
    function automatic logic signed [COORD_W-1:0] widen_lo(
        logic signed [COORD_W-1:0] c,
        logic [MARGIN_W-1:0]       m
    );
        logic signed [COORD_W:0] s;
        s = (COORD_W+1)'(c) - $signed({3'b000, m});
        if (s[COORD_W] != s[COORD_W-1]) begin
            return COORD_MIN;
        end
        return s[COORD_W-1:0];
    endfunction

    // high side plus margin, clamped at the most positive coordinate
    function automatic logic signed [COORD_W-1:0] widen_hi(
        logic signed [COORD_W-1:0] c,
        logic [MARGIN_W-1:0]       m
    );
        logic signed [COORD_W:0] s;
        s = (COORD_W+1)'(c) + $signed({3'b000, m});
        if (s[COORD_W] != s[COORD_W-1]) begin
            return COORD_MAX;
        end
        return s[COORD_W-1:0];
    endfunction

endpackage

/* sv/aabbbp_match.sv */
// ============================================================================
// aabbbp_match
// Pair test: inclusive box overlap on three axes plus optional shared-vertex
// rejection between a stored element and the element under test.
// ============================================================================
module aabbbp_match
    import aabbbp_pkg::*;
#(
    parameter int VERTS_PER_ELEMENT = 3
) (
    input  t_entry i_stored,
    input  t_entry i_probe,
    input  logic   i_skip_neighbors,
    output logic   o_hit
);

    logic [VERT_W-1:0] stored_v [3];
    logic [VERT_W-1:0] probe_v  [3];
    logic              overlap;
    logic              shared;

    always_comb begin
        stored_v[0] = i_stored.va;
        stored_v[1] = i_stored.vb;
        stored_v[2] = i_stored.vc;
        probe_v[0]  = i_probe.va;
        probe_v[1]  = i_probe.vb;
        probe_v[2]  = i_probe.vc;

        overlap = (i_stored.lo.x <= i_probe.hi.x) && (i_probe.lo.x <= i_stored.hi.x) &&
                  (i_stored.lo.y <= i_probe.hi.y) && (i_probe.lo.y <= i_stored.hi.y) &&
                  (i_stored.lo.z <= i_probe.hi.z) && (i_probe.lo.z <= i_stored.hi.z);

        shared = 1'b0;
        for (int i = 0; i < VERTS_PER_ELEMENT; i++) begin
            for (int j = 0; j < VERTS_PER_ELEMENT; j++) begin
                if (stored_v[i] == probe_v[j]) begin
                    shared = 1'b1;
                end
            end
        end

        o_hit = overlap && !(i_skip_neighbors && shared);
    end

endmodule

/* sv/aabb_pair_broad_phase.sv */
// ============================================================================
// aabb_pair_broad_phase
// Brute-force self-collision broad phase: widens each new element box by the
// margin, tests it against every stored element and reports the hit pairs.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ------------------------------
//  request   in         i_in_valid / o_in_stall      operation, vertex_a..c,
//                                                    low_x..z, high_x..z
//  result    out        o_out_valid / i_out_stall    earlier_index, new_index,
//                                                    dropped, last
//  config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
//  steps: a clear resets the count; an add against n stored elements makes n element
//    reads, compares each one, drains the held hit, then writes the store
//  an add into a full store gives one dropped result and leaves the store as is
//  reset: synchronous, active low; only entries below the count are ever read
//  stalls: a stalled result holds the output register; the scan runs on until a
//    second hit has to leave, then the read pipe freezes in place
//
module aabb_pair_broad_phase
    import aabbbp_pkg::*;
#(
    parameter int CAPACITY          = 64,
    parameter int VERTS_PER_ELEMENT = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [VERT_W-1:0]            i_vertex_a,
    input  logic [VERT_W-1:0]            i_vertex_b,
    input  logic [VERT_W-1:0]            i_vertex_c,
    input  logic signed [COORD_W-1:0]    i_low_x,
    input  logic signed [COORD_W-1:0]    i_low_y,
    input  logic signed [COORD_W-1:0]    i_low_z,
    input  logic signed [COORD_W-1:0]    i_high_x,
    input  logic signed [COORD_W-1:0]    i_high_y,
    input  logic signed [COORD_W-1:0]    i_high_z,

    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [OUT_IDX_W-1:0]         o_earlier_index,
    output logic [OUT_IDX_W-1:0]         o_new_index,
    output logic                         o_dropped,
    output logic                         o_last,

    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // store index and fill count widths
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DROP  = 2'd3;

    // element store, one entry per element
    t_entry r_mem [CAPACITY];

    logic [1:0]            r_state,  n_state;
    logic [CW-1:0]         r_count,  n_count;
    t_entry                r_new,    n_new;
    logic [CW-1:0]         r_rd_idx, n_rd_idx;
    t_entry                r_rd_data;
    logic                  r_cmp_valid, n_cmp_valid;
    logic [IW-1:0]         r_cmp_idx,   n_cmp_idx;
    logic                  r_pend_valid, n_pend_valid;
    logic [IW-1:0]         r_pend_idx,   n_pend_idx;
    logic                  r_out_valid,  n_out_valid;
    logic [OUT_IDX_W-1:0]  r_out_earlier, n_out_earlier;
    logic [OUT_IDX_W-1:0]  r_out_new,     n_out_new;
    logic                  r_out_dropped, n_out_dropped;
    logic                  r_out_last,    n_out_last;
    logic [MARGIN_W-1:0]   r_margin;
    logic                  r_skip;

    logic                  in_acc;
    logic                  out_free;
    logic                  issuing;
    logic                  hit;
    logic                  advance;
    logic                  rd_en;
    logic                  wr_en;
    t_entry                in_entry;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign issuing  = (r_rd_idx < r_count);

    // the scan only stalls when a second hit finds the output still busy
    assign advance = !(r_cmp_valid && hit && r_pend_valid && !out_free);
    assign rd_en   = (r_state == S_SCAN) && advance && issuing;
    assign wr_en   = (r_state == S_FLUSH) && (!r_pend_valid || out_free);

    // widened box of the incoming element
    always_comb begin
        in_entry.va   = i_vertex_a;
        in_entry.vb   = i_vertex_b;
        in_entry.vc   = i_vertex_c;
        in_entry.lo.x = widen_lo(i_low_x, r_margin);
        in_entry.lo.y = widen_lo(i_low_y, r_margin);
        in_entry.lo.z = widen_lo(i_low_z, r_margin);
        in_entry.hi.x = widen_hi(i_high_x, r_margin);
        in_entry.hi.y = widen_hi(i_high_y, r_margin);
        in_entry.hi.z = widen_hi(i_high_z, r_margin);
    end

    aabbbp_match #(
        .VERTS_PER_ELEMENT (VERTS_PER_ELEMENT)
    ) u_match (
        .i_stored         (r_rd_data),
        .i_probe          (r_new),
        .i_skip_neighbors (r_skip),
        .o_hit            (hit)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_new         = r_new;
        n_rd_idx      = r_rd_idx;
        n_cmp_valid   = r_cmp_valid;
        n_cmp_idx     = r_cmp_idx;
        n_pend_valid  = r_pend_valid;
        n_pend_idx    = r_pend_idx;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_earlier = r_out_earlier;
        n_out_new     = r_out_new;
        n_out_dropped = r_out_dropped;
        n_out_last    = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == OP_CLEAR) begin
                        n_count = '0;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_state = S_DROP;
                    end else begin
                        n_new        = in_entry;
                        n_rd_idx     = '0;
                        n_cmp_valid  = 1'b0;
                        n_pend_valid = 1'b0;
                        n_state      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (advance) begin
                    n_cmp_valid = issuing;
                    if (issuing) begin
                        n_cmp_idx = r_rd_idx[IW-1:0];
                        n_rd_idx  = r_rd_idx + 1'b1;
                    end
                    // a new hit retires the held one, which cannot be the last
                    if (r_cmp_valid && hit) begin
                        if (r_pend_valid) begin
                            n_out_valid   = 1'b1;
                            n_out_earlier = OUT_IDX_W'(r_pend_idx);
                            n_out_new     = OUT_IDX_W'(r_count[IW-1:0]);
                            n_out_dropped = 1'b0;
                            n_out_last    = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_cmp_idx;
                    end
                    if (!issuing && !r_cmp_valid) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid   = 1'b1;
                        n_out_earlier = OUT_IDX_W'(r_pend_idx);
                        n_out_new     = OUT_IDX_W'(r_count[IW-1:0]);
                        n_out_dropped = 1'b0;
                        n_out_last    = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_count      = r_count + 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DROP: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_earlier = '0;
                    n_out_new     = '0;
                    n_out_dropped = 1'b1;
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IW-1:0]] <= r_new;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_new         <= n_new;
        r_rd_idx      <= n_rd_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_pend_idx    <= n_pend_idx;
        r_out_earlier <= n_out_earlier;
        r_out_new     <= n_out_new;
        r_out_dropped <= n_out_dropped;
        r_out_last    <= n_out_last;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cmp_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_cmp_valid  <= n_cmp_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
            r_skip   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MARGIN: r_margin <= i_cfg_data[MARGIN_W-1:0];
                CFG_SKIP:   r_skip   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_earlier_index = r_out_earlier;
    assign o_new_index     = r_out_new;
    assign o_dropped       = r_out_dropped;
    assign o_last          = r_out_last;

    // fill count never passes the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    // an element is only stored into a free slot
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_count < CW'(CAPACITY)))
        else $error("element write into a full store");

    // the compare stage and the held hit exist only during a scan or its flush
    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid || r_cmp_valid) |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("scan pipeline active outside a scan");

    // every read hits an entry below the fill count
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd_idx < r_count))
        else $error("read beyond stored elements");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking regression for aabb_pair_broad_phase. A shadow copy of the
// element store predicts every reported pair, and one checker compares each
// result in order. Both channels idle at random, and the margin and
// neighbour skipping settings are swept between phases.
// ============================================================================
module testbench;
    import aabbbp_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int VERTS         = 3;
    // an add with no hit gives no result but keeps the block busy for a full
    // scan of the store, so give it that plus some slack
    localparam int SETTLE_CYCLES = CAPACITY + 16;
    // ~370 requests, each at most a full scan plus 63 stalled results;
    // the limit leaves ample room for a typical run
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 40;
    localparam int C_LO          = -524288;
    localparam int C_HI          = 524287;
    localparam logic [MARGIN_W-1:0] MARGIN_MAX = '1;

    // one reported pair as it leaves the block
    typedef struct packed {
        logic [OUT_IDX_W-1:0] earlier;
        logic [OUT_IDX_W-1:0] slot;
        logic                 dropped;
        logic                 last;
    } t_pair;

    // dut inputs, all known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_operation = OP_CLEAR;
    logic [VERT_W-1:0]     i_vertex_a  = '0;
    logic [VERT_W-1:0]     i_vertex_b  = '0;
    logic [VERT_W-1:0]     i_vertex_c  = '0;
    logic [COORD_W-1:0]    i_low_x     = '0;
    logic [COORD_W-1:0]    i_low_y     = '0;
    logic [COORD_W-1:0]    i_low_z     = '0;
    logic [COORD_W-1:0]    i_high_x    = '0;
    logic [COORD_W-1:0]    i_high_y    = '0;
    logic [COORD_W-1:0]    i_high_z    = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_MARGIN;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // dut outputs
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [OUT_IDX_W-1:0]  o_earlier_index;
    logic [OUT_IDX_W-1:0]  o_new_index;
    logic                  o_dropped;
    logic                  o_last;

    // shadow of the block: settings and element store
    logic [MARGIN_W-1:0]   cur_margin = '0;
    logic                  cur_skip   = 1'b1;
    int                    stored_count = 0;
    logic [VERT_W-1:0]     shadow_verts[CAPACITY][VERTS];
    int                    shadow_lo[CAPACITY][3];
    int                    shadow_hi[CAPACITY][3];

    // pairs predicted but not yet seen, oldest first
    t_pair                 pending_pairs[$];
    t_pair                 head_pair;

    // run bookkeeping
    bit                    steady = 1'b0;   // no idling on either side
    int                    err_count = 0;
    int                    cycle_count = 0;
    int                    requests_sent = 0;
    int                    adds_sent = 0;
    int                    clears_sent = 0;
    int                    results_checked = 0;
    int                    drops_seen = 0;
    int                    cfg_writes = 0;

    // random cluster where well-formed elements land
    int                    base_x, base_y, base_z;
    logic [VERT_W-1:0]     vert_base;

    aabb_pair_broad_phase #(
        .CAPACITY          (CAPACITY),
        .VERTS_PER_ELEMENT (VERTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_vertex_a      (i_vertex_a),
        .i_vertex_b      (i_vertex_b),
        .i_vertex_c      (i_vertex_c),
        .i_low_x         (i_low_x),
        .i_low_y         (i_low_y),
        .i_low_z         (i_low_z),
        .i_high_x        (i_high_x),
        .i_high_y        (i_high_y),
        .i_high_z        (i_high_z),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_earlier_index (o_earlier_index),
        .o_new_index     (o_new_index),
        .o_dropped       (o_dropped),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pairs outstanding",
                     cycle_count, pending_pairs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side stalls about a third of the time, never while steady
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < 33);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch on %s: got %0d, want %0d (result %0d, cycle %0d)",
                     what, got, want, results_checked, cycle_count);
        end
    endtask

    // every accepted result against the oldest predicted pair
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (o_dropped) begin
                drops_seen++;
            end
            if (pending_pairs.size() == 0) begin
                report_mismatch("result with nothing pending", o_earlier_index, -1);
            end else begin
                head_pair = pending_pairs[0];
                pending_pairs.delete(0);
                if (o_earlier_index !== head_pair.earlier) begin
                    report_mismatch("earlier_index", o_earlier_index, head_pair.earlier);
                end
                if (o_new_index !== head_pair.slot) begin
                    report_mismatch("new_index", o_new_index, head_pair.slot);
                end
                if (o_dropped !== head_pair.dropped) begin
                    report_mismatch("dropped", o_dropped, head_pair.dropped);
                end
                if (o_last !== head_pair.last) begin
                    report_mismatch("last", o_last, head_pair.last);
                end
            end
        end
    end

    // box side moved outward by the margin, clamped to the coordinate range
    function automatic int widen(input logic signed [COORD_W-1:0] c, input bit upward);
        int v;
        v = upward ? int'(c) + int'(cur_margin) : int'(c) - int'(cur_margin);
        if (v < C_LO) begin
            v = C_LO;
        end
        if (v > C_HI) begin
            v = C_HI;
        end
        return v;
    endfunction

    // shadow of one accepted request: queues its pairs, then updates the store
    task automatic predict_pairs(input logic op, input t_entry e);
        int                lo[3];
        int                hi[3];
        logic [VERT_W-1:0] verts[VERTS];
        t_pair             found[$];
        t_pair             p;
        bit                hit;
        bit                shared;
        int                k, d, i, j;
        if (op == OP_CLEAR) begin
            stored_count = 0;
            return;
        end
        if (stored_count >= CAPACITY) begin
            // full store: a single dropped marker, store untouched
            p = '0;
            p.dropped = 1'b1;
            p.last = 1'b1;
            pending_pairs = {pending_pairs, p};
            return;
        end
        verts[0] = e.va;
        verts[1] = e.vb;
        verts[2] = e.vc;
        lo[0] = widen(e.lo.x, 1'b0);
        lo[1] = widen(e.lo.y, 1'b0);
        lo[2] = widen(e.lo.z, 1'b0);
        hi[0] = widen(e.hi.x, 1'b1);
        hi[1] = widen(e.hi.y, 1'b1);
        hi[2] = widen(e.hi.z, 1'b1);
        for (k = 0; k < stored_count; k++) begin
            // inclusive overlap on every axis, inverted boxes taken as given
            hit = 1'b1;
            for (d = 0; d < 3; d++) begin
                if (!(shadow_lo[k][d] <= hi[d] && lo[d] <= shadow_hi[k][d])) begin
                    hit = 1'b0;
                end
            end
            shared = 1'b0;
            for (i = 0; i < VERTS; i++) begin
                for (j = 0; j < VERTS; j++) begin
                    if (shadow_verts[k][i] == verts[j]) begin
                        shared = 1'b1;
                    end
                end
            end
            if (hit && !(cur_skip && shared)) begin
                p = '0;
                p.earlier = OUT_IDX_W'(k);
                p.slot = OUT_IDX_W'(stored_count);
                found = {found, p};
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        for (i = 0; i < found.size(); i++) begin
            pending_pairs = {pending_pairs, found[i]};
        end
        for (d = 0; d < 3; d++) begin
            shadow_verts[stored_count][d] = verts[d];
            shadow_lo[stored_count][d] = lo[d];
            shadow_hi[stored_count][d] = hi[d];
        end
        stored_count++;
    endtask

    // one request: random idle gap, then hold until accepted
    task automatic send_request(input logic op, input t_entry e);
        if (!steady) begin
            while ($urandom_range(0, 99) < 33) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_vertex_a  <= e.va;
        i_vertex_b  <= e.vb;
        i_vertex_c  <= e.vc;
        i_low_x     <= e.lo.x;
        i_low_y     <= e.lo.y;
        i_low_z     <= e.lo.z;
        i_high_x    <= e.hi.x;
        i_high_y    <= e.hi.y;
        i_high_z    <= e.hi.z;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_pairs(op, e);
        requests_sent++;
        if (op == OP_ADD) begin
            adds_sent++;
        end else begin
            clears_sent++;
        end
    endtask

    // hold off until every pair is back and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MARGIN) begin
            cur_margin = val[MARGIN_W-1:0];
        end else if (idx == CFG_SKIP) begin
            cur_skip = val[0];
        end
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // new settings only once the block is idle
    task automatic set_config(input logic [MARGIN_W-1:0] m, input logic skip);
        settle();
        write_reg(CFG_MARGIN, m);
        write_reg(CFG_SKIP, CFG_DATA_W'(skip));
    endtask

    function automatic logic [MARGIN_W-1:0] pick_margin();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return MARGIN_MAX;
            2: return MARGIN_W'($urandom_range(0, 3000));
            default: return MARGIN_W'($urandom);
        endcase
    endfunction

    function automatic t_entry mk_elem(input int va, input int vb, input int vc,
                                       input int lx, input int ly, input int lz,
                                       input int hx, input int hy, input int hz);
        t_entry e;
        e.va = va[VERT_W-1:0];
        e.vb = vb[VERT_W-1:0];
        e.vc = vc[VERT_W-1:0];
        e.lo.x = lx[COORD_W-1:0];
        e.lo.y = ly[COORD_W-1:0];
        e.lo.z = lz[COORD_W-1:0];
        e.hi.x = hx[COORD_W-1:0];
        e.hi.y = hy[COORD_W-1:0];
        e.hi.z = hz[COORD_W-1:0];
        return e;
    endfunction

    // any bit pattern at all
    function automatic t_entry noise_entry();
        t_entry e;
        e.va = VERT_W'($urandom);
        e.vb = VERT_W'($urandom);
        e.vc = VERT_W'($urandom);
        e.lo.x = COORD_W'($urandom);
        e.lo.y = COORD_W'($urandom);
        e.lo.z = COORD_W'($urandom);
        e.hi.x = COORD_W'($urandom);
        e.hi.y = COORD_W'($urandom);
        e.hi.z = COORD_W'($urandom);
        return e;
    endfunction

    // cluster origin, sometimes hard against the coordinate limits
    function automatic int pick_base();
        case ($urandom_range(0, 6))
            0: return C_LO;
            1: return C_HI - 4500;
            default: return int'($urandom_range(0, 1040000)) + C_LO;
        endcase
    endfunction

    task automatic new_cluster();
        base_x = pick_base();
        base_y = pick_base();
        base_z = pick_base();
        vert_base = VERT_W'($urandom);
    endtask

    // element near the current cluster: boxes overlap often, vertices repeat
    function automatic t_entry cluster_entry();
        int lx, ly, lz, hx, hy, hz, t;
        lx = base_x + int'($urandom_range(0, 3000));
        ly = base_y + int'($urandom_range(0, 3000));
        lz = base_z + int'($urandom_range(0, 3000));
        hx = lx + int'($urandom_range(0, 1500));
        hy = ly + int'($urandom_range(0, 1500));
        hz = lz + int'($urandom_range(0, 1500));
        if ($urandom_range(0, 3) == 0) begin
            // planar element
            lz = 0;
            hz = 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            // inverted box
            t = lx;
            lx = hx;
            hx = t;
        end
        cluster_entry = mk_elem(int'(vert_base) + int'($urandom_range(0, 20)),
                                int'(vert_base) + int'($urandom_range(0, 20)),
                                int'(vert_base) + int'($urandom_range(0, 20)),
                                lx, ly, lz, hx, hy, hz);
        if ($urandom_range(0, 4) == 0) begin
            // two-vertex element
            cluster_entry.vc = cluster_entry.vb;
        end
    endfunction

    // reset settings: margin 0, neighbour skipping on
    task automatic test_directed_pairs();
        send_request(OP_CLEAR, '0);
        send_request(OP_ADD, mk_elem(0, 1, 2, 0, 0, 0, 100, 100, 100));
        // corner touch, but shares a vertex
        send_request(OP_ADD, mk_elem(2, 3, 4, 100, 100, 100, 200, 200, 200));
        // face touch with the first element only
        send_request(OP_ADD, mk_elem(5, 6, 7, 100, 0, 0, 150, 50, 50));
        // two-vertex element spanning the whole space
        send_request(OP_ADD, mk_elem(65535, 65534, 65534, C_LO, C_LO, C_LO, C_HI, C_HI, C_HI));
        // inverted on x
        send_request(OP_ADD, mk_elem(8, 9, 9, 50, 0, 0, 40, 100, 100));
        send_request(OP_ADD, mk_elem(10, 11, 12, C_LO, C_LO, C_LO, C_LO, C_LO, C_LO));
        send_request(OP_ADD, mk_elem(13, 14, 15, C_HI, C_HI, C_HI, C_HI, C_HI, C_HI));
        // shares the big element's vertex through its third index
        send_request(OP_ADD, mk_elem(16, 17, 65535, 0, 0, 0, 100, 100, 100));
        // one past the first element on x
        send_request(OP_ADD, mk_elem(18, 19, 20, 101, 0, 0, 200, 100, 100));
        send_request(OP_ADD, mk_elem(21, 22, 23, 0, 0, 0, 0, 0, 0));
        send_request(OP_CLEAR, '0);
        send_request(OP_CLEAR, noise_entry());
        // empty store: no pair possible
        send_request(OP_ADD, mk_elem(0, 1, 2, 0, 0, 0, 10, 10, 10));
        send_request(OP_ADD, mk_elem(43690, 21845, 65535,
                                     -349526, 349525, -349526, 349525, -349526, 349525));
        send_request(OP_ADD, mk_elem(21845, 43690, 0,
                                     349525, -349526, 349525, -349526, 349525, -349526));
        send_request(OP_ADD, mk_elem(0, 0, 0, -1, -1, -1, 0, 0, 0));
    endtask

    // margin extremes with saturation, skipping off and on
    task automatic test_margin_and_skip();
        set_config(MARGIN_MAX, 1'b0);
        send_request(OP_CLEAR, '0);
        send_request(OP_ADD, mk_elem(1, 2, 3, C_LO, C_LO, C_LO, C_LO, C_LO, C_LO));
        send_request(OP_ADD, mk_elem(1, 4, 5, C_HI, C_HI, C_HI, C_HI, C_HI, C_HI));
        send_request(OP_ADD, mk_elem(1, 6, 7, 0, 0, 0, 0, 0, 0));
        send_request(OP_ADD, mk_elem(8, 9, 10, -262145, -262145, -262145,
                                     -262145, -262145, -262145));
        set_config('0, 1'b1);
        send_request(OP_CLEAR, '0);
        send_request(OP_ADD, mk_elem(1, 2, 3, 0, 0, 0, 10, 10, 10));
        send_request(OP_ADD, mk_elem(4, 5, 6, 11, 0, 0, 20, 10, 10));
        // a margin of one closes the gap
        set_config(MARGIN_W'(1), 1'b1);
        send_request(OP_CLEAR, '0);
        send_request(OP_ADD, mk_elem(1, 2, 3, 0, 0, 0, 10, 10, 10));
        send_request(OP_ADD, mk_elem(4, 5, 6, 12, 0, 0, 20, 10, 10));
        set_config(pick_margin(), 1'b0);
        new_cluster();
        repeat (6) send_request(OP_ADD, cluster_entry());
    endtask

    // fill the store with boxes around the origin, then overflow it
    task automatic test_full_store();
        set_config('0, 1'b0);
        send_request(OP_CLEAR, '0);
        repeat (CAPACITY + 3) begin
            send_request(OP_ADD, mk_elem($urandom, $urandom, $urandom,
                                         -int'($urandom_range(0, 5000)),
                                         -int'($urandom_range(0, 5000)),
                                         -int'($urandom_range(0, 5000)),
                                         $urandom_range(0, 5000),
                                         $urandom_range(0, 5000),
                                         $urandom_range(0, 5000)));
        end
        send_request(OP_CLEAR, '0);
        send_request(OP_ADD, cluster_entry());
    endtask

    // long stretch with no idling on either side
    task automatic test_back_to_back();
        settle();
        steady = 1'b1;
        new_cluster();
        send_request(OP_CLEAR, '0);
        repeat (30) send_request(OP_ADD, cluster_entry());
        settle();
        steady = 1'b0;
    endtask

    // runs of clustered adds after a clear, with noise, stray clears and
    // occasional new settings or a full drain
    task automatic test_random_mix();
        int start, len, pick;
        start = requests_sent;
        while (requests_sent - start < 230) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                set_config(pick_margin(), 1'($urandom_range(0, 1)));
            end else if (pick == 3) begin
                settle();
            end
            new_cluster();
            if ($urandom_range(0, 4) != 0) begin
                send_request(OP_CLEAR, '0);
            end
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 72)
                                                : $urandom_range(1, 16);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    send_request(OP_ADD, cluster_entry());
                end else if (pick < 95) begin
                    send_request(1'($urandom_range(0, 1)), noise_entry());
                end else begin
                    send_request(OP_CLEAR, noise_entry());
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_pairs();
        test_margin_and_skip();
        test_full_store();
        test_back_to_back();
        test_random_mix();
        settle();

        $display("covered %0d requests (%0d adds, %0d clears), %0d results, %0d dropped",
                 requests_sent, adds_sent, clears_sent, results_checked, drops_seen);
        $display("%0d register writes, %0d mismatches, %0d cycles",
                 cfg_writes, err_count, cycle_count);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
